// ===== rtl/hpt_pkg.sv =====
// Shared widths, register indexes, payload types and the output saturation
// function of the homogeneous point transform. No dependencies.
`default_nettype none

package hpt_pkg;

    localparam int CW        = 32;            // coordinate / matrix entry width
    localparam int CFG_W     = 64;
    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = $clog2(CFG_NUM);
    localparam int PW        = 2 * CW;        // one product
    localparam int HW        = PW + 2;        // row sum, Q32.32 plus guard
    localparam int FRAC      = 16;
    localparam int NW        = HW + FRAC;     // dividend magnitude
    localparam int QW        = 32;
    localparam int NQ        = QW + 1;        // quotient bits incl. overflow bit
    localparam int CMPW      = HW + NQ;

    localparam int DOT_STAGES  = 3;
    localparam int DIV_STAGES  = NQ + 1;
    localparam int PIPE_STAGES = DOT_STAGES + DIV_STAGES;

    localparam int IN_W      = 3 * CW;
    localparam int OUT_W     = 3 * QW;
    localparam int USER_W    = 2;
    localparam int USER_WZ   = 0;
    localparam int USER_CLIP = 1;

    localparam int REG_ROW0_COLS01 = 0;
    localparam int REG_ROW0_COLS23 = 1;
    localparam int REG_ROW1_COLS01 = 2;
    localparam int REG_ROW1_COLS23 = 3;
    localparam int REG_ROW2_COLS01 = 4;
    localparam int REG_ROW2_COLS23 = 5;
    localparam int REG_ROW3_COLS01 = 6;
    localparam int REG_ROW3_COLS23 = 7;

    localparam logic [CW-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [QW-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] Q_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic signed [CW-1:0] m3;
        logic signed [CW-1:0] m2;
        logic signed [CW-1:0] m1;
        logic signed [CW-1:0] m0;
    } coef_row_t;

    typedef struct packed {
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
    } div_res_t;

    typedef struct packed {
        logic [QW-1:0] val;
        logic          clip;
    } sat_t;

    function automatic sat_t sat_q16(input div_res_t r);
        sat_t s;
        s.clip = 1'b0;
        s.val  = r.q;
        if (r.ovf)
        begin
            s.clip = 1'b1;
            s.val  = r.neg ? Q_MIN : Q_MAX;
        end
        else if (r.neg)
        begin
            if (r.q > Q_MIN)
            begin
                s.clip = 1'b1;
                s.val  = Q_MIN;
            end
            else
            begin
                s.val = ~r.q + 1'b1;
            end
        end
        else if (r.q > Q_MAX)
        begin
            s.clip = 1'b1;
            s.val  = Q_MAX;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/homogeneous_point_transform.sv =====
// Homogeneous point transform: 4x4 matrix times (x, y, z, 1), perspective
// divide and Q16.16 saturation. Depends on hpt_pkg, hpt_dot and hpt_div.
//
// Usage:
//   Input stream s_axis_*: one point per request, tdata = {z, y, x}, Q16.16.
//   Output stream m_axis_*: tdata = {z', y', x'} Q16.16, tuser = {clipped,
//   w_was_zero}. One result per point, in order.
//   Config port: cfg_we/cfg_index/cfg_data write one 64-bit matrix register
//   per cycle; indexes 8 and up are ignored. Write only while idle.
// Timing:
//   A point passes through 3 multiply/sum stages, 1 sign stage, 33 divider
//   stages (one quotient bit each) and the output register. One point per
//   cycle sustained while the skid entry is empty.
// Reset:
//   Matrix returns to identity, the pipeline and output empty.
// Backpressure:
//   An output register plus one skid entry sit after the pipeline. While the
//   output waits, the pipeline keeps running until the skid entry fills;
//   then the whole pipeline holds and s_axis_tready drops.
`default_nettype none

module homogeneous_point_transform (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hpt_pkg::IN_W-1:0]          s_axis_tdata,   // point_x, point_y, point_z
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hpt_pkg::OUT_W-1:0]         m_axis_tdata,   // out_x, out_y, out_z
    output logic [hpt_pkg::USER_W-1:0]        m_axis_tuser    // w_was_zero, clipped
);
    import hpt_pkg::*;

    logic [CFG_W-1:0]      cfg_reg [0:CFG_NUM-1];
    coef_row_t             coef    [0:3];
    logic signed [CW-1:0]  vx;
    logic signed [CW-1:0]  vy;
    logic signed [CW-1:0]  vz;
    logic signed [HW-1:0]  h       [0:3];
    div_res_t              dres    [0:2];
    sat_t                  sat     [0:2];
    logic                  adv;
    logic                  incoming;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] wz_reg;
    logic [OUT_W-1:0]      res_data;
    logic [USER_W-1:0]     res_user;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic [USER_W-1:0]     out_user_reg;
    logic                  skid_valid_reg;
    logic [OUT_W-1:0]      skid_data_reg;
    logic [USER_W-1:0]     skid_user_reg;

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW0_COLS01] <= CFG_W'(ONE_Q16);
            cfg_reg[REG_ROW0_COLS23] <= '0;
            cfg_reg[REG_ROW1_COLS01] <= {ONE_Q16, {CW{1'b0}}};
            cfg_reg[REG_ROW1_COLS23] <= '0;
            cfg_reg[REG_ROW2_COLS01] <= '0;
            cfg_reg[REG_ROW2_COLS23] <= CFG_W'(ONE_Q16);
            cfg_reg[REG_ROW3_COLS01] <= '0;
            cfg_reg[REG_ROW3_COLS23] <= {ONE_Q16, {CW{1'b0}}};
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(CFG_NUM)))
        begin
            cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            coef[r].m0 = cfg_reg[2*r][CW-1:0];
            coef[r].m1 = cfg_reg[2*r][CFG_W-1:CW];
            coef[r].m2 = cfg_reg[2*r+1][CW-1:0];
            coef[r].m3 = cfg_reg[2*r+1][CFG_W-1:CW];
        end
    end

    assign vx = s_axis_tdata[CW-1:0];
    assign vy = s_axis_tdata[2*CW-1:CW];
    assign vz = s_axis_tdata[3*CW-1:2*CW];

    // whole pipeline moves unless the skid entry is holding a result
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign incoming      = adv && vld_reg[PIPE_STAGES-1];

    for (genvar r = 0; r < 4; r++)
    begin : g_dot
        hpt_dot u_dot (
            .clk  (clk),
            .en   (adv),
            .coef (coef[r]),
            .vx   (vx),
            .vy   (vy),
            .vz   (vz),
            .h    (h[r])
        );
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_div
        hpt_div u_div (
            .clk (clk),
            .en  (adv),
            .num (h[l]),
            .den (h[3]),
            .res (dres[l])
        );
        assign sat[l] = sat_q16(dres[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wz_reg <= {wz_reg[DIV_STAGES-2:0], (h[3] == '0)};
        end
    end

    always_comb
    begin
        if (wz_reg[DIV_STAGES-1])
        begin
            res_data            = '0;
            res_user            = '0;
            res_user[USER_WZ]   = 1'b1;
        end
        else
        begin
            res_data            = {sat[2].val, sat[1].val, sat[0].val};
            res_user            = '0;
            res_user[USER_CLIP] = sat[0].clip | sat[1].clip | sat[2].clip;
        end
    end

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg  <= skid_valid_reg || incoming;
            skid_valid_reg <= 1'b0;
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
            out_user_reg <= skid_valid_reg ? skid_user_reg : res_user;
        end
        else if (incoming)
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_user;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while output is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid entry filled without an output stall");

    a_last_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PIPE_STAGES-1] && adv) |=> out_valid_reg)
        else $error("result leaving the pipeline was dropped");

    a_wzero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_WZ])
            |-> (m_axis_tdata == '0 && !m_axis_tuser[USER_CLIP]))
        else $error("zero-w result carries data or clip flag");
`endif

endmodule

`default_nettype wire

// ===== rtl/hpt_dot.sv =====
// One matrix row times (x, y, z, 1): three registered stages
// (products, pair sums, row sum). Depends on hpt_pkg.
`default_nettype none

module hpt_dot (
    input  logic                           clk,
    input  logic                           en,
    input  hpt_pkg::coef_row_t             coef,
    input  logic signed [hpt_pkg::CW-1:0]  vx,
    input  logic signed [hpt_pkg::CW-1:0]  vy,
    input  logic signed [hpt_pkg::CW-1:0]  vz,
    output logic signed [hpt_pkg::HW-1:0]  h
);
    import hpt_pkg::*;

    logic signed [PW-1:0] p0_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [CW-1:0] m3_reg;
    logic signed [HW-1:0] sa_reg;
    logic signed [HW-1:0] sb_reg;
    logic signed [HW-1:0] h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= PW'(coef.m0) * PW'(vx);
            p1_reg <= PW'(coef.m1) * PW'(vy);
            p2_reg <= PW'(coef.m2) * PW'(vz);
            m3_reg <= coef.m3;
            sa_reg <= HW'(p0_reg) + HW'(p1_reg);
            // w = 1.0 in Q16.16: column 3 times one is a shift
            sb_reg <= HW'(p2_reg) + (HW'(m3_reg) <<< FRAC);
            h_reg  <= sa_reg + sb_reg;
        end
    end

    assign h = h_reg;

endmodule

`default_nettype wire

// ===== rtl/hpt_div.sv =====
// Pipelined restoring divider: |num| * 2^16 / |den|, one sign/magnitude stage
// then one quotient bit per stage (overflow bit first). Depends on hpt_pkg.
`default_nettype none

module hpt_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [hpt_pkg::HW-1:0]  num,
    input  logic signed [hpt_pkg::HW-1:0]  den,
    output hpt_pkg::div_res_t              res
);
    import hpt_pkg::*;

    logic [NW-1:0]   r_reg   [0:NQ-1];
    logic [HW-1:0]   d_reg   [0:NQ-1];
    logic [NQ-1:0]   q_reg   [0:NQ];
    logic            neg_reg [0:NQ];
    logic [HW-1:0]   n_mag;
    logic [HW-1:0]   d_mag;
    logic [CMPW-1:0] trial   [1:NQ];
    logic            ge      [1:NQ];

    assign n_mag = num[HW-1] ? -num : num;
    assign d_mag = den[HW-1] ? -den : den;

    always_comb
    begin
        for (int k = 1; k <= NQ; k++)
        begin
            trial[k] = CMPW'(d_reg[k-1]) << (NQ - k);
            ge[k]    = CMPW'(r_reg[k-1]) >= trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= {n_mag, {FRAC{1'b0}}};
            d_reg[0]   <= d_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[HW-1] ^ den[HW-1];
            for (int k = 1; k <= NQ; k++)
            begin
                q_reg[k]   <= q_reg[k-1] | (NQ'(ge[k]) << (NQ - k));
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 1; k < NQ; k++)
            begin
                r_reg[k] <= ge[k] ? r_reg[k-1] - trial[k][NW-1:0] : r_reg[k-1];
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    assign res.q   = q_reg[NQ][QW-1:0];
    assign res.ovf = q_reg[NQ][QW];
    assign res.neg = neg_reg[NQ];

endmodule

`default_nettype wire
